// ===== hdl/msl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msl_pkg;

   localparam int NUM_MOTORS_DEF = 10;
   localparam int NUM_MOTORS_MAX = 16;

   localparam int PORT_W   = 4;
   localparam int DRIVE_W  = 8;
   localparam int STEP_W   = 7;
   localparam int PERIOD_W = 8;
   localparam int MASK_W   = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   localparam logic [STEP_W-1:0]   STEP_LIMIT_RST  = STEP_W'(20);
   localparam logic [PERIOD_W-1:0] PASS_PERIOD_RST = PERIOD_W'(20);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_LIMIT  = 2'd0,
      CSR_PASS_PERIOD = 2'd1,
      CSR_MOTOR_EN    = 2'd2,
      CSR_RUNNING     = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_SET  = 1'b0,
      MODE_TICK = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PASS
   } state_type;

   // bit of the active mask for a motor; motors past the mask width are never active
   function automatic logic mask_bit(input logic [MASK_W-1:0] mask,
                                     input logic [PORT_W-1:0] idx);
      logic r;
      r = 1'b0;
      if (idx < PORT_W'(MASK_W)) begin
         r = mask[idx];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/multi_motor_slew_limiter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Set item: decided in the cycle after acceptance; a direct write loads the result register
//   and waits while it is full, a stored target or an out-of-range port gives no result.
// Tick item: on a slew pass the single approach unit visits the motors one after another;
//   the pass waits while the result register is full.
// Requests: ready only while idle, so a new item waits until the last one is done.
// Reset (synchronous, active high): registers to defaults, all targets, drives and count zero.
module multi_motor_slew_limiter_core
   import msl_pkg::*;
#(
   parameter int NUM_MOTORS = NUM_MOTORS_DEF
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request item
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,   // [3:0] motor_port, [11:4] speed, rest zero
   input  wire logic                    req_tuser,   // [0] mode
   // result item
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [RSP_TDATA_W-1:0]  rsp_tdata,   // [3:0] out_port, [11:4] drive, rest zero
   output logic                         rsp_tlast,
   // register writes
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam logic [PORT_W:0] NUM_L = (PORT_W + 1)'(NUM_MOTORS);

   // configuration registers
   logic [STEP_W-1:0]   step_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic                running_ff;

   // motor state
   logic signed [DRIVE_W-1:0] target_ff [NUM_MOTORS];
   logic signed [DRIVE_W-1:0] drive_ff  [NUM_MOTORS];
   logic [PERIOD_W-1:0]       count_ff, count_in;

   // sequencer
   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      mode_ff;
   logic [PORT_W-1:0]         port_ff;
   logic signed [DRIVE_W-1:0] speed_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0]         rsp_port_ff, rsp_port_in;
   logic signed [DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic                      rsp_last_ff, rsp_last_in;

   // array write strobes
   logic                      tgt_we, drv_we;
   logic [IDX_W-1:0]          wr_idx;
   logic signed [DRIVE_W-1:0] drv_wdata;

   logic                      req_acc;
   logic                      slot_free;
   logic                      port_ok;
   logic [PORT_W-1:0]         idx_port;
   logic                      cur_active;
   logic                      more_active;
   logic signed [DRIVE_W-1:0] step_drive;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   // result register may load when empty or being emptied this cycle
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign port_ok    = ({1'b0, port_ff} < NUM_L);
   assign idx_port   = PORT_W'(idx_ff);
   assign cur_active = mask_bit(mask_ff, idx_port);

   always_comb begin
      more_active = 1'b0;
      for (int j = 0; j < NUM_MOTORS; j++) begin
         if ((PORT_W'(j) > idx_port) && mask_bit(mask_ff, PORT_W'(j))) begin
            more_active = 1'b1;
         end
      end
   end

   msl_approach u_approach (
      .from_drive (drive_ff[idx_ff]),
      .to_drive   (target_ff[idx_ff]),
      .limit      (step_ff),
      .new_drive  (step_drive)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_port_in  = rsp_port_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_last_in  = rsp_last_ff;
      tgt_we       = 1'b0;
      drv_we       = 1'b0;
      wr_idx       = port_ff[IDX_W-1:0];
      drv_wdata    = speed_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (mode_ff == MODE_SET) begin
               if (!port_ok) begin
                  state_in = ST_IDLE;
               end else if (mask_bit(mask_ff, port_ff) && running_ff) begin
                  tgt_we   = 1'b1;
                  state_in = ST_IDLE;
               end else if (slot_free) begin
                  drv_we       = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_port_in  = port_ff;
                  rsp_drive_in = speed_ff;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               if (!running_ff) begin
                  state_in = ST_IDLE;
               end else if (count_ff != '0) begin
                  count_in = count_ff - PERIOD_W'(1);
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            wr_idx    = idx_ff;
            drv_wdata = step_drive;
            if (!cur_active || slot_free) begin
               if (cur_active) begin
                  drv_we       = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_port_in  = idx_port;
                  rsp_drive_in = step_drive;
                  rsp_last_in  = !more_active;
               end
               if (more_active) begin
                  idx_in = idx_ff + IDX_W'(1);
               end else begin
                  // pass done: reload, zero period acts as one
                  count_in = (period_ff == '0) ? '0 : period_ff - PERIOD_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_port_ff  <= rsp_port_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_last_ff  <= rsp_last_in;
      if (req_acc) begin
         mode_ff  <= req_tuser;
         port_ff  <= req_tdata[PORT_W-1:0];
         speed_ff <= req_tdata[PORT_W+DRIVE_W-1:PORT_W];
      end
   end

   // targets and drives
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MOTORS; i++) begin
            target_ff[i] <= '0;
            drive_ff[i]  <= '0;
         end
      end else begin
         if (tgt_we) begin
            target_ff[wr_idx] <= speed_ff;
         end
         if (drv_we) begin
            drive_ff[wr_idx] <= drv_wdata;
         end
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_LIMIT_RST;
         period_ff  <= PASS_PERIOD_RST;
         mask_ff    <= '0;
         running_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_LIMIT:  step_ff    <= csr_data[STEP_W-1:0];
            CSR_PASS_PERIOD: period_ff  <= csr_data[PERIOD_W-1:0];
            CSR_MOTOR_EN:    mask_ff    <= csr_data[MASK_W-1:0];
            CSR_RUNNING:     running_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - PORT_W - DRIVE_W)'(0), rsp_drive_ff, rsp_port_ff};

   // checks
   a_acc_exec: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_EXEC)
      else $error("accepted item not taken to decode");

   a_pass_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PASS |-> running_ff)
      else $error("slew pass while stopped");

   a_rsp_port: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_port_ff} < NUM_L))
      else $error("result for motor out of range");

   a_pass_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PASS |-> ({1'b0, idx_port} < NUM_L))
      else $error("pass index out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff)
      else $error("held result dropped");

endmodule

`default_nettype wire

// ===== hdl/msl_approach.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared slew step: move from toward to by at most limit.
module msl_approach
   import msl_pkg::*;
(
   input  wire logic signed [DRIVE_W-1:0] from_drive,
   input  wire logic signed [DRIVE_W-1:0] to_drive,
   input  wire logic        [STEP_W-1:0]  limit,
   output logic      signed [DRIVE_W-1:0] new_drive
);

   logic signed [DRIVE_W:0] diff;
   logic signed [DRIVE_W:0] lim_pos;
   logic signed [DRIVE_W:0] lim_neg;
   logic signed [DRIVE_W:0] from_x;
   logic signed [DRIVE_W:0] sum;

   always_comb begin
      from_x  = {from_drive[DRIVE_W-1], from_drive};
      diff    = {to_drive[DRIVE_W-1], to_drive} - from_x;
      lim_pos = {2'b00, limit};
      lim_neg = -lim_pos;
      if (diff > lim_pos) begin
         sum = from_x + lim_pos;
      end else if (diff < lim_neg) begin
         sum = from_x - lim_pos;
      end else begin
         sum = {to_drive[DRIVE_W-1], to_drive};
      end
      // result lies between from and to, so it fits the drive width
      new_drive = sum[DRIVE_W-1:0];
   end

endmodule

`default_nettype wire

// ===== bench/multi_motor_slew_limiter_core_tb.sv =====
`timescale 1ns / 1ps

module multi_motor_slew_limiter_core_tb;
   import msl_pkg::*;

   localparam int NUM_MOTORS   = NUM_MOTORS_DEF;
   localparam int SETTLE_CYC   = 4 * (NUM_MOTORS + 2);
   localparam int CYCLE_LIMIT  = 800000;
   localparam int PHASE_ITEMS  = 44;

   typedef struct packed {
      logic [PORT_W-1:0]         out_port;
      logic signed [DRIVE_W-1:0] drive;
      logic                      last;
   } drive_result_type;

   // Predicts the drive writes of the slew limiter and checks them in order.
   class slew_scoreboard;
      logic [STEP_W-1:0]         step_limit;
      logic [PERIOD_W-1:0]       pass_period;
      logic [MASK_W-1:0]         motor_en;
      logic                      running;
      logic signed [DRIVE_W-1:0] target[NUM_MOTORS];
      logic signed [DRIVE_W-1:0] drive_now[NUM_MOTORS];
      logic [PERIOD_W-1:0]       countdown;
      drive_result_type          expected_q[$];
      int                        errors;

      function new();
         step_limit  = STEP_LIMIT_RST;
         pass_period = PASS_PERIOD_RST;
         motor_en    = '0;
         running     = 1'b0;
         countdown   = '0;
         errors      = 0;
         for (int i = 0; i < NUM_MOTORS; i++) begin
            target[i]    = '0;
            drive_now[i] = '0;
         end
      endfunction

      function void apply_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_STEP_LIMIT:  step_limit  = val[STEP_W-1:0];
            CSR_PASS_PERIOD: pass_period = val[PERIOD_W-1:0];
            CSR_MOTOR_EN:    motor_en    = val[MASK_W-1:0];
            CSR_RUNNING:     running     = val[0];
            default: ;
         endcase
      endfunction

      function logic signed [DRIVE_W-1:0] slew_toward(logic signed [DRIVE_W-1:0] from,
                                                     logic signed [DRIVE_W-1:0] goal);
         int lim;
         int diff;
         lim  = int'(step_limit);
         diff = int'(goal) - int'(from);
         if (diff > lim) return DRIVE_W'(int'(from) + lim);
         if (diff < -lim) return DRIVE_W'(int'(from) - lim);
         return goal;
      endfunction

      function void note_item(mode_type mode, logic [PORT_W-1:0] port,
                              logic signed [DRIVE_W-1:0] speed);
         drive_result_type r;
         drive_result_type batch[$];
         if (mode == MODE_SET) begin
            if (port >= NUM_MOTORS) return;
            if (running && motor_en[port]) begin
               target[port] = speed;
               return;
            end
            drive_now[port] = speed;
            r.out_port = port;
            r.drive    = speed;
            r.last     = 1'b1;
            expected_q.push_back(r);
            return;
         end
         if (!running) return;
         if (countdown != 0) begin
            countdown = countdown - 1'b1;
            return;
         end
         for (int i = 0; i < NUM_MOTORS; i++) begin
            if (motor_en[i]) begin
               drive_now[i] = slew_toward(drive_now[i], target[i]);
               r.out_port = PORT_W'(i);
               r.drive    = drive_now[i];
               r.last     = 1'b0;
               batch.push_back(r);
            end
         end
         if (batch.size() > 0) begin
            r = batch.pop_back();
            r.last = 1'b1;
            batch.push_back(r);
         end
         foreach (batch[k]) expected_q.push_back(batch[k]);
         countdown = (pass_period == 0) ? '0 : pass_period - 1'b1;
      endfunction

      function void check_result(logic [PORT_W-1:0] port, logic signed [DRIVE_W-1:0] drive,
                                 logic last);
         drive_result_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected item: out_port %0d drive %0d last %0b", port, drive, last);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (e.out_port !== port) begin
            $error("out_port: expected %0d, got %0d", e.out_port, port);
            errors++;
         end
         if (e.drive !== drive) begin
            $error("drive: expected %0d, got %0d", e.drive, drive);
            errors++;
         end
         if (e.last !== last) begin
            $error("last: expected %0b, got %0b", e.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   slew_scoreboard sb = new();
   bit             no_idle = 1'b0;
   int             cycle_count = 0;
   int             stall_left = 0;

   multi_motor_slew_limiter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly back to back, now and then a short gap, rarely a long one
   function automatic int idle_cycles();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** multi_motor_slew_limiter_core: FAILED **");
         $finish;
      end
   end

   // result side: random back-pressure, check every accepted item
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata[3:0], rsp_tdata[11:4], rsp_tlast);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < 20) stall_left <= idle_cycles();
         end
      end
   end

   // called at a rising edge; leaves tvalid high so the next item may follow directly
   task automatic send_item(mode_type mode, logic [PORT_W-1:0] port,
                            logic signed [DRIVE_W-1:0] speed);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, speed, port};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      sb.note_item(mode, port, speed);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.apply_csr(idx, val);
   endtask

   // block must be idle: drain, then let any pass with no output finish
   task automatic set_regs(int step, int period, int mask, bit run);
      drain();
      repeat (SETTLE_CYC) @(posedge clock);
      write_csr(CSR_STEP_LIMIT, CSR_DATA_W'(step));
      write_csr(CSR_PASS_PERIOD, CSR_DATA_W'(period));
      write_csr(CSR_MOTOR_EN, CSR_DATA_W'(mask));
      write_csr(CSR_RUNNING, CSR_DATA_W'(run));
      csr_valid <= 1'b0;
   endtask

   task automatic directed_items();
      // stopped: every set to a motor in range writes directly
      send_item(MODE_SET, 4'd0, -8'sd128);
      send_item(MODE_SET, 4'd9, 8'sd127);
      send_item(MODE_SET, 4'd1, 8'sd0);
      send_item(MODE_SET, 4'd2, -8'sd1);
      send_item(MODE_SET, 4'd10, 8'sd5);       // port out of range
      send_item(MODE_SET, 4'd15, 8'sh55);      // port out of range
      send_item(MODE_TICK, 4'd0, 8'sd0);       // tick while stopped
      // all motors slewing, a pass on every tick
      set_regs(5, 0, 10'h3FF, 1'b1);
      send_item(MODE_SET, 4'd0, 8'sd127);
      send_item(MODE_SET, 4'd9, -8'sd128);
      send_item(MODE_TICK, 4'd0, 8'sd0);
      send_item(MODE_TICK, 4'd0, 8'sd0);
      // widest step: lands on target, then repeats unchanged drive
      set_regs(127, 0, 10'h201, 1'b1);
      send_item(MODE_SET, 4'd3, 8'sd42);       // inactive motor while running
      send_item(MODE_TICK, 4'd0, 8'sd0);
      send_item(MODE_TICK, 4'd0, 8'sd0);
      send_item(MODE_TICK, 4'd0, 8'sd0);
      // no active motor, zero step, countdown through a period
      set_regs(0, 3, 0, 1'b1);
      repeat (4) send_item(MODE_TICK, 4'd0, 8'sd0);
   endtask

   task automatic random_items(int count, bit pause_midway);
      mode_type          mode;
      logic [PORT_W-1:0] port;
      for (int k = 0; k < count; k++) begin
         if (pause_midway && k == count / 2) drain();
         mode = ($urandom_range(0, 99) < 45) ? MODE_TICK : MODE_SET;
         if ($urandom_range(0, 99) < 12) port = PORT_W'($urandom_range(NUM_MOTORS, 15));
         else port = PORT_W'($urandom_range(0, NUM_MOTORS - 1));
         send_item(mode, port, DRIVE_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      directed_items();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_regs(127, 0, 10'h3FF, 1'b1);
            1: set_regs(0, 1, $urandom_range(0, 1023), 1'b1);
            2: set_regs($urandom_range(0, 127), 255, 10'h3FF, 1'b1);
            3: set_regs($urandom_range(0, 127), $urandom_range(0, 7),
                        $urandom_range(0, 1023), 1'b0);
            4: set_regs($urandom_range(1, 127), 2, 0, 1'b1);
            default: set_regs($urandom_range(1, 127), $urandom_range(0, 4),
                              $urandom_range(0, 1023), 1'b1);
         endcase
         no_idle = (ph == 5);
         random_items(PHASE_ITEMS, ph == 0);
      end
      no_idle = 1'b0;
      drain();
      repeat (SETTLE_CYC) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** multi_motor_slew_limiter_core: PASSED **");
      end else begin
         $display("** multi_motor_slew_limiter_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/msl_pkg.sv
hdl/msl_approach.sv
hdl/multi_motor_slew_limiter_core.sv
bench/multi_motor_slew_limiter_core_tb.sv
